// ----- rtl/hiap_pkg.sv -----
package hiap_pkg;

    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int BOUND_W   = 31;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 3;
    // mag * 10 + 9 with mag <= 2^31 fits in 35 bits
    localparam int WIDE_W    = VALUE_W + 3;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_WS     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TAIL   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FAIL   = 3'd4;

    // coerce kinds
    localparam logic [KIND_W-1:0] KIND_SIGNED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONNEG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POS     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLAMPED = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COERCE_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH    = 2'd3;

    localparam logic [WIDE_W-1:0]  MAG_LIMIT      = 35'h0_8000_0000;
    localparam logic [BOUND_W-1:0] CLAMP_HIGH_RST = 31'h7fff_ffff;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0c;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_FF) ||
               (c == CH_CR) || (c == CH_SPACE);
    endfunction

    function automatic logic is_dec(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- rtl/html_integer_attribute_parser_top.sv -----
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    char_byte, has_char, is_last
// out       source     out_valid / out_ready  value, took_default
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless a result waits on out_ready. The item ending a value passes
// the input register, then parse state and snapshot, then coerce into the output register,
// where its result is valid.
// The parse state loop (multiply by ten, add, limit compare) sets the cycle time.
// All stages hold while a result waits on out_ready; in_ready drops only then.
// rst_n clears parse state and valid bits and sets the configuration registers to their reset values.
// cfg_ready is always high.
module html_integer_attribute_parser_top
    import hiap_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CHAR_W-1:0]           char_byte,
    input  logic                        has_char,
    input  logic                        is_last,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [VALUE_W-1:0]   value,
    output logic                        took_default,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [VALUE_W-1:0]          cfg_data
);

    logic                advance;

    // configuration
    logic [KIND_W-1:0]   kind_reg;
    logic [VALUE_W-1:0]  default_reg;
    logic [BOUND_W-1:0]  low_reg;
    logic [BOUND_W-1:0]  high_reg;

    // input register
    logic                s1_valid_reg;
    logic [CHAR_W-1:0]   s1_char_reg;
    logic                s1_has_reg;
    logic                s1_last_reg;

    // parse state
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                ovf_reg, ovf_next;

    // finished value waiting for coercion
    logic                snap_valid_reg;
    logic                snap_parsed_reg;
    logic                snap_neg_reg;
    logic [VALUE_W-1:0]  snap_mag_reg;
    logic                snap_ovf_reg;

    // output register
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                dflt_reg, dflt_next;

    logic [WIDE_W-1:0]   mag_wide;
    logic [VALUE_W-1:0]  clamp_up;
    logic                snap_is_neg;
    logic                ok;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign took_default = dflt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_SIGNED;
            default_reg <= '0;
            low_reg     <= '0;
            high_reg    <= CLAMP_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COERCE_KIND:   kind_reg    <= cfg_data[KIND_W-1:0];
                REG_DEFAULT_VALUE: default_reg <= cfg_data;
                REG_CLAMP_LOW:     low_reg     <= cfg_data[BOUND_W-1:0];
                REG_CLAMP_HIGH:    high_reg    <= cfg_data[BOUND_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_char_reg <= char_byte;
            s1_has_reg  <= has_char;
            s1_last_reg <= is_last;
        end
    end

    // mag * 10 + digit
    assign mag_wide = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1)
                    + {{(WIDE_W-4){1'b0}}, s1_char_reg[3:0]};

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        if (s1_has_reg)
        begin
            unique case (phase_reg)
                PH_WS:
                begin
                    if (is_ws(s1_char_reg))
                    begin
                        phase_next = PH_WS;
                    end
                    else if (s1_char_reg == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (s1_char_reg == CH_PLUS)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else if (is_dec(s1_char_reg))
                    begin
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_SIGN:
                begin
                    phase_next = is_dec(s1_char_reg) ? PH_DIGITS : PH_FAIL;
                end
                PH_DIGITS:
                begin
                    if (!is_dec(s1_char_reg))
                    begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:   ;
                default:   phase_next = PH_FAIL;
            endcase

            // digit accepted in whitespace, sign or digits phase
            if (is_dec(s1_char_reg) &&
                (phase_reg == PH_WS || phase_reg == PH_SIGN || phase_reg == PH_DIGITS))
            begin
                if (mag_wide > MAG_LIMIT)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    mag_next = mag_wide[VALUE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WS;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            ovf_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            snap_valid_reg <= s1_valid_reg && s1_last_reg;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    phase_reg <= PH_WS;
                    neg_reg   <= 1'b0;
                    mag_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            snap_parsed_reg <= (phase_next == PH_DIGITS) || (phase_next == PH_TAIL);
            snap_neg_reg    <= neg_next;
            snap_mag_reg    <= mag_next;
            snap_ovf_reg    <= ovf_next;
        end
    end

    // coerce
    assign snap_is_neg = snap_neg_reg && (snap_mag_reg != '0);
    assign clamp_up    = (snap_mag_reg < {1'b0, low_reg}) ? {1'b0, low_reg} : snap_mag_reg;

    always_comb
    begin
        ok         = 1'b0;
        value_next = snap_mag_reg;
        unique case (kind_reg)
            KIND_SIGNED:
            begin
                ok         = !snap_ovf_reg && (snap_is_neg || !snap_mag_reg[VALUE_W-1]);
                value_next = snap_is_neg ? (~snap_mag_reg + 1'b1) : snap_mag_reg;
            end
            KIND_NONNEG:
            begin
                ok = !snap_is_neg && !snap_ovf_reg && !snap_mag_reg[VALUE_W-1];
            end
            KIND_POS:
            begin
                ok = !snap_is_neg && !snap_ovf_reg && !snap_mag_reg[VALUE_W-1] &&
                     (snap_mag_reg != '0);
            end
            KIND_CLAMPED:
            begin
                ok = !snap_is_neg;
                // an overflowed value always sits above clamp_high
                if (snap_ovf_reg || (clamp_up > {1'b0, high_reg}))
                begin
                    value_next = {1'b0, high_reg};
                end
                else
                begin
                    value_next = clamp_up;
                end
            end
            default: ;
        endcase
        ok        = ok && snap_parsed_reg;
        dflt_next = !ok;
        if (!ok)
        begin
            value_next = default_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= value_next;
            dflt_reg  <= dflt_next;
        end
    end

endmodule

// ----- rtl/hiap_checker.sv -----
module hiap_checker
    import hiap_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [VALUE_W-1:0] value,
    input logic                      took_default,
    input logic                      cfg_ready
);

    // a held result keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // and its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value) && $stable(took_default))
        else $error("result changed while stalled");

    // the input side stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // with the receiver ready, a waiting input item is taken on the same edge
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && out_ready |-> in_ready)
        else $error("input not taken while output is ready");

    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port stalled");

endmodule

bind html_integer_attribute_parser_top hiap_checker u_hiap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .took_default (took_default),
    .cfg_ready    (cfg_ready)
);
